// ===== sv/wfba_pkg.sv =====
// Shared widths, codes and controller/datapath interface types of the worst-fit allocator.
`default_nettype none

package wfba_pkg;

  // Fixed field widths of the stream beats and the configuration register
  localparam int unsigned INDEX_W   = 5;
  localparam int unsigned SIZE_IN_W = 16;
  localparam int unsigned CFG_W     = 6;
  localparam int unsigned TDATA_W   = 24;
  localparam int unsigned PAD_W     = TDATA_W - INDEX_W - SIZE_IN_W;

  // Reset value of the blocks-in-use register
  localparam logic [CFG_W-1:0] CFG_RESET = 6'd32;

  // Opcodes carried in s_axis_tuser
  localparam logic OP_LOAD    = 1'b0;
  localparam logic OP_REQUEST = 1'b1;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;     // write a free size for a load beat
    logic start;    // capture a request and clear the scan
    logic scan_rd;  // read the entry at the scan index, advance it
    logic finish;   // write back the chosen block, load the output register
  } wfba_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic n_zero;     // no block in use
    logic scan_last;  // scan index sits on the last block in use
    logic out_free;   // output register can take a result this cycle
  } wfba_sts_t;

endpackage

`default_nettype wire

// ===== sv/wfba_ctrl.sv =====
// Sequencer for load and request beats of the worst-fit allocator.
`default_nettype none

module wfba_ctrl import wfba_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  input  wire logic      in_opcode_i,
  output logic           in_ready_o,
  input  wire wfba_sts_t sts_i,
  output wfba_cmd_t      cmd_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_LAST,
    ST_FINISH
  } state_e;

  state_e state_q, state_d;
  logic   accept;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  // Commands decoded from the state
  always_comb begin
    cmd_o         = '0;
    cmd_o.load    = accept && (in_opcode_i == OP_LOAD);
    cmd_o.start   = accept && (in_opcode_i == OP_REQUEST);
    cmd_o.scan_rd = (state_q == ST_SCAN);
    cmd_o.finish  = (state_q == ST_FINISH) && sts_i.out_free;
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (cmd_o.start) begin
          state_d = sts_i.n_zero ? ST_FINISH : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (sts_i.scan_last) begin
          state_d = ST_LAST;
        end
      end
      // last read entry is compared here
      ST_LAST: begin
        state_d = ST_FINISH;
      end
      ST_FINISH: begin
        if (sts_i.out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

// ===== sv/wfba_dp.sv =====
// Free-size memory, scan compare, write-back and output register of the allocator.
`default_nettype none

module wfba_dp import wfba_pkg::*; #(
  parameter int unsigned BLOCK_COUNT = 32,
  parameter int unsigned SIZE_WIDTH  = 16
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_W-1:0]     cfg_wdata_i,
  input  wire logic [INDEX_W-1:0]   in_index_i,
  input  wire logic [SIZE_IN_W-1:0] in_size_i,
  input  wire wfba_cmd_t            cmd_i,
  output wfba_sts_t                 sts_o,
  input  wire logic                 out_ready_i,
  output logic                      out_valid_o,
  output logic                      out_alloc_o,
  output logic [INDEX_W-1:0]        out_block_o,
  output logic [SIZE_IN_W-1:0]      out_remain_o
);

  localparam int unsigned AW    = (BLOCK_COUNT > 1) ? $clog2(BLOCK_COUNT) : 1;
  localparam int unsigned CNT_W = $clog2(BLOCK_COUNT + 1);
  localparam int unsigned NW    = (CNT_W > CFG_W) ? CNT_W : CFG_W;
  localparam logic [NW-1:0] BlockCnt = NW'(BLOCK_COUNT);

  logic [CFG_W-1:0]      cfg_q;
  logic [NW-1:0]         cfg_ext, n_eff;
  logic                  load_hit;

  logic [SIZE_WIDTH-1:0] mem_q [BLOCK_COUNT];
  logic [BLOCK_COUNT-1:0] valid_q;
  logic                  mem_we;
  logic [AW-1:0]         mem_waddr;
  logic [SIZE_WIDTH-1:0] mem_wdata;

  logic [AW-1:0]         scan_idx_q;
  logic [SIZE_WIDTH-1:0] rd_q;
  logic                  rd_vld_q;
  logic [AW-1:0]         rd_idx_q;
  logic                  cmp_q;
  logic [SIZE_WIDTH-1:0] entry;
  logic                  take;

  logic [SIZE_WIDTH-1:0] req_q;
  logic                  found_q;
  logic [AW-1:0]         best_idx_q;
  logic [SIZE_WIDTH-1:0] best_sz_q;
  logic [SIZE_WIDTH-1:0] remain;

  logic                  out_valid_q;
  logic                  out_alloc_q;
  logic [INDEX_W-1:0]    out_block_q;
  logic [SIZE_IN_W-1:0]  out_remain_q;

  // Blocks in use, clamped to the table depth
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RESET;
    end else if (cfg_we_i) begin
      cfg_q <= cfg_wdata_i;
    end
  end

  assign cfg_ext  = NW'(cfg_q);
  assign n_eff    = (cfg_ext > BlockCnt) ? BlockCnt : cfg_ext;
  assign load_hit = (NW'(in_index_i) < n_eff);

  // Status to the controller
  always_comb begin
    sts_o           = '0;
    sts_o.n_zero    = (n_eff == '0);
    sts_o.scan_last = (NW'(scan_idx_q) == (n_eff - NW'(1)));
    sts_o.out_free  = !out_valid_q || out_ready_i;
  end

  // Write port: load beats and allocation write-back
  assign remain    = best_sz_q - req_q;
  assign mem_we    = (cmd_i.load && load_hit) || (cmd_i.finish && found_q);
  assign mem_waddr = cmd_i.load ? AW'(in_index_i) : best_idx_q;
  assign mem_wdata = cmd_i.load ? SIZE_WIDTH'(in_size_i) : remain;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    rd_q <= mem_q[scan_idx_q];
  end

  // Written-entry flags; an unwritten entry reads as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (mem_we) begin
      valid_q[mem_waddr] <= 1'b1;
    end
  end

  // Scan index and read pipeline
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmp_q <= 1'b0;
    end else begin
      cmp_q <= cmd_i.scan_rd;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      scan_idx_q <= '0;
    end else if (cmd_i.scan_rd) begin
      scan_idx_q <= scan_idx_q + AW'(1);
    end
    rd_idx_q <= scan_idx_q;
    rd_vld_q <= valid_q[scan_idx_q];
  end

  // Worst-fit compare: largest fitting size, first index wins a tie
  assign entry = rd_vld_q ? rd_q : '0;
  assign take  = cmp_q && (entry >= req_q) && (!found_q || (entry > best_sz_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q <= 1'b0;
    end else if (cmd_i.start) begin
      found_q <= 1'b0;
    end else if (take) begin
      found_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      req_q <= SIZE_WIDTH'(in_size_i);
    end
    if (take) begin
      best_idx_q <= rd_idx_q;
      best_sz_q  <= entry;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.finish) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      out_alloc_q  <= found_q;
      out_block_q  <= found_q ? INDEX_W'(best_idx_q) : '0;
      out_remain_q <= found_q ? SIZE_IN_W'(remain) : '0;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_alloc_o  = out_alloc_q;
  assign out_block_o  = out_block_q;
  assign out_remain_o = out_remain_q;

endmodule

`default_nettype wire

// ===== sv/worst_fit_block_allocator_unit.sv =====
// Top level of the worst-fit block allocator.
// A load beat (tuser 0) writes one block's free size and gives no
// result; a load beyond the blocks in use is dropped. A request beat (tuser 1) scans
// the free-size memory one entry per cycle through its single read port and takes the
// largest size that fits, lowest index on a tie, then writes the reduced size back;
// the scan covers the blocks in use clamped to BLOCK_COUNT and is skipped with no
// block in use. The input is ready only between items, while the result register
// lets the next beat be taken before the previous result is drained. After reset
// every free size reads as zero through per-entry written flags, so no clearing
// pass is needed.
`default_nettype none

module worst_fit_block_allocator_unit import wfba_pkg::*; #(
  parameter int unsigned BLOCK_COUNT = 32,
  parameter int unsigned SIZE_WIDTH  = 16
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [CFG_W-1:0]   cfg_wdata_i,    // blocks_in_use
  input  wire logic               s_axis_tvalid,
  output logic                    s_axis_tready,
  input  wire logic [TDATA_W-1:0] s_axis_tdata,   // block_index, size_value, zero pad
  input  wire logic               s_axis_tuser,   // opcode
  output logic                    m_axis_tvalid,
  input  wire logic               m_axis_tready,
  output logic [TDATA_W-1:0]      m_axis_tdata,   // chosen_block, block_remaining, zero pad
  output logic                    m_axis_tuser    // allocated
);

  wfba_cmd_t            cmd;
  wfba_sts_t            sts;
  logic                 out_alloc;
  logic [INDEX_W-1:0]   out_block;
  logic [SIZE_IN_W-1:0] out_remain;

  wfba_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_opcode_i (s_axis_tuser),
    .in_ready_o  (s_axis_tready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  wfba_dp #(
    .BLOCK_COUNT (BLOCK_COUNT),
    .SIZE_WIDTH  (SIZE_WIDTH)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_index_i   (s_axis_tdata[INDEX_W-1:0]),
    .in_size_i    (s_axis_tdata[INDEX_W+SIZE_IN_W-1:INDEX_W]),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .out_ready_i  (m_axis_tready),
    .out_valid_o  (m_axis_tvalid),
    .out_alloc_o  (out_alloc),
    .out_block_o  (out_block),
    .out_remain_o (out_remain)
  );

  // Pack the result beat
  assign m_axis_tdata = {{PAD_W{1'b0}}, out_remain, out_block};
  assign m_axis_tuser = out_alloc;

  // A failed request carries all-zero data
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata == '0))
    else $error("not-allocated result with nonzero data");

  // A request beat holds off the input while it scans
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready && (s_axis_tuser == OP_REQUEST)) |=> !s_axis_tready)
    else $error("input ready during a request scan");

  // A load beat leaves the input ready again in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready && (s_axis_tuser == OP_LOAD)) |=> s_axis_tready)
    else $error("input not ready after a load beat");

endmodule

`default_nettype wire

// ===== bench/wfba_grant_checker.sv =====
// Checker for the worst-fit allocator: predicts each grant beat and compares it with the DUT.
`timescale 1ns / 100ps

module wfba_grant_checker import wfba_pkg::*; #(
  parameter int unsigned BLOCK_COUNT = 32
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [CFG_W-1:0]   cfg_wdata_i,    // blocks_in_use
  input  wire logic               s_axis_tvalid,
  input  wire logic               s_axis_tready,
  input  wire logic [TDATA_W-1:0] s_axis_tdata,   // block_index, size_value, zero pad
  input  wire logic               s_axis_tuser,   // opcode
  input  wire logic               m_axis_tvalid,
  input  wire logic               m_axis_tready,
  input  wire logic [TDATA_W-1:0] m_axis_tdata,   // chosen_block, block_remaining, zero pad
  input  wire logic               m_axis_tuser,   // allocated
  output int                      mismatch_count,
  output int                      grants_waiting,
  output int                      grants_checked,
  output int                      grants_made
);

  // One predicted grant beat
  typedef struct packed {
    logic                 allocated;
    logic [INDEX_W-1:0]   block;
    logic [SIZE_IN_W-1:0] remaining;
  } grant_t;

  logic [SIZE_IN_W-1:0] free_tbl [BLOCK_COUNT];
  logic [CFG_W-1:0]     blocks_cfg;
  grant_t               grant_q [$];

  // Blocks a beat may touch: register value clamped to the table size
  function automatic int unsigned active_blocks();
    return (blocks_cfg > BLOCK_COUNT) ? BLOCK_COUNT : int'(blocks_cfg);
  endfunction

  // Apply one accepted input beat to the free-size table; requests queue a grant
  function automatic void take_beat(input logic op, input logic [INDEX_W-1:0] idx,
                                    input logic [SIZE_IN_W-1:0] amount);
    int unsigned n;
    int unsigned best;
    bit          found;
    grant_t      g;
    n     = active_blocks();
    best  = 0;
    found = 1'b0;
    g     = '0;
    if (op == OP_LOAD) begin
      // loads past the blocks in use are dropped
      if (idx < n) free_tbl[idx] = amount;
      return;
    end
    // largest fitting size, strict compare keeps the lowest index on ties
    for (int unsigned k = 0; k < n; k++) begin
      if (free_tbl[k] >= amount && (!found || free_tbl[k] > free_tbl[best])) begin
        best  = k;
        found = 1'b1;
      end
    end
    if (found) begin
      free_tbl[best] = free_tbl[best] - amount;
      g.allocated    = 1'b1;
      g.block        = INDEX_W'(best);
      g.remaining    = free_tbl[best];
      grants_made++;
    end
    grant_q.push_back(g);
  endfunction

  // Watch config, grant and request channels at each edge
  always @(posedge clk_i or negedge rst_ni) begin
    grant_t exp_g;
    grant_t got_g;
    if (!rst_ni) begin
      foreach (free_tbl[k]) free_tbl[k] = '0;
      blocks_cfg     = CFG_RESET;
      grant_q.delete();
      mismatch_count = 0;
      grants_waiting = 0;
      grants_checked = 0;
      grants_made    = 0;
    end else begin
      if (cfg_we_i) blocks_cfg = cfg_wdata_i;

      // grant beat: compare against the oldest prediction
      if (m_axis_tvalid && m_axis_tready) begin
        got_g.allocated = m_axis_tuser;
        got_g.block     = m_axis_tdata[INDEX_W-1:0];
        got_g.remaining = m_axis_tdata[INDEX_W +: SIZE_IN_W];
        if (grant_q.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("%0t: grant beat with none pending: alloc=%0b block=%0d rem=%0d",
                     $realtime, got_g.allocated, got_g.block, got_g.remaining);
        end else begin
          exp_g = grant_q.pop_front();
          grants_checked++;
          if (got_g.allocated !== exp_g.allocated || got_g.block !== exp_g.block ||
              got_g.remaining !== exp_g.remaining) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("%0t: grant mismatch: exp alloc=%0b block=%0d rem=%0d, got alloc=%0b block=%0d rem=%0d",
                       $realtime, exp_g.allocated, exp_g.block, exp_g.remaining,
                       got_g.allocated, got_g.block, got_g.remaining);
          end
        end
      end

      // request/load beat
      if (s_axis_tvalid && s_axis_tready)
        take_beat(s_axis_tuser, s_axis_tdata[INDEX_W-1:0], s_axis_tdata[INDEX_W +: SIZE_IN_W]);

      grants_waiting = grant_q.size();
    end
  end

endmodule

// ===== bench/tb_worst_fit_block_allocator_unit.sv =====
// Testbench top for the worst-fit allocator: reset, clock, stimulus and verdict.
`timescale 1ns / 100ps

module tb_worst_fit_block_allocator_unit;
  import wfba_pkg::*;

  localparam int unsigned BLOCK_COUNT   = 32;
  localparam int          SETTLE_CYCLES = BLOCK_COUNT + 8;
  localparam int          HOLD_CYCLES   = 400;

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               cfg_we_i;
  logic [CFG_W-1:0]   cfg_wdata_i;
  logic               s_axis_tvalid;
  logic               s_axis_tready;
  logic [TDATA_W-1:0] s_axis_tdata;
  logic               s_axis_tuser;
  logic               m_axis_tvalid;
  logic               m_axis_tready;
  logic [TDATA_W-1:0] m_axis_tdata;
  logic               m_axis_tuser;

  int mismatch_count;
  int grants_waiting;
  int grants_checked;
  int grants_made;

  // stimulus bookkeeping
  logic [CFG_W-1:0] cur_blocks = CFG_RESET;
  bit               quiet = 1'b0;
  int               hold_req_cnt = 0;
  int               hold_ack_cnt = 0;
  int               loads_sent = 0;
  int               requests_sent = 0;
  int               settings_run = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  worst_fit_block_allocator_unit #(
    .BLOCK_COUNT (BLOCK_COUNT),
    .SIZE_WIDTH  (SIZE_IN_W)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  wfba_grant_checker #(
    .BLOCK_COUNT (BLOCK_COUNT)
  ) u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .s_axis_tvalid  (s_axis_tvalid),
    .s_axis_tready  (s_axis_tready),
    .s_axis_tdata   (s_axis_tdata),
    .s_axis_tuser   (s_axis_tuser),
    .m_axis_tvalid  (m_axis_tvalid),
    .m_axis_tready  (m_axis_tready),
    .m_axis_tdata   (m_axis_tdata),
    .m_axis_tuser   (m_axis_tuser),
    .mismatch_count (mismatch_count),
    .grants_waiting (grants_waiting),
    .grants_checked (grants_checked),
    .grants_made    (grants_made)
  );

  // Grant side: random stall bursts, plus a long hold-off on request
  initial begin
    m_axis_tready <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (hold_req_cnt != hold_ack_cnt) begin
        hold_ack_cnt = hold_ack_cnt + 1;
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
    end
  end

  // Offer one beat, with an occasional idle burst first, and wait for the handshake
  task automatic send_beat(input logic op, input logic [INDEX_W-1:0] idx,
                           input logic [SIZE_IN_W-1:0] amount);
    int gap;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 19);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {{PAD_W{1'b0}}, amount, idx};
    do @(posedge clk_i); while (!s_axis_tready);
    if (op == OP_LOAD) loads_sent++;
    else requests_sent++;
  endtask

  // Stop offering, wait out all grants, then let a trailing load finish
  task automatic drain_and_settle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (grants_waiting != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_block_count(input logic [CFG_W-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    cur_blocks  = value;
    settings_run++;
  endtask

  // Random beat: mostly small requests against loaded sizes, some loads and odd sizes
  task automatic random_item();
    int unsigned          span;
    logic [INDEX_W-1:0]   idx;
    logic [SIZE_IN_W-1:0] amount;
    span = (cur_blocks == 0) ? 1 : ((cur_blocks > BLOCK_COUNT) ? BLOCK_COUNT : cur_blocks);
    idx  = INDEX_W'($urandom_range(0, 31));
    if ($urandom_range(0, 99) < 25) begin
      // loads mostly land inside the blocks in use
      if ($urandom_range(0, 7) != 0) idx = INDEX_W'($urandom_range(0, span - 1));
      case ($urandom_range(0, 3))
        0:       amount = SIZE_IN_W'($urandom_range(0, 255));
        1:       amount = '1;
        default: amount = SIZE_IN_W'($urandom_range(0, 65535));
      endcase
      send_beat(OP_LOAD, idx, amount);
    end else begin
      case ($urandom_range(0, 9))
        0:       amount = '0;
        1:       amount = SIZE_IN_W'($urandom_range(0, 65535));
        2:       amount = '1;
        default: amount = SIZE_IN_W'($urandom_range(1, 2000));
      endcase
      send_beat(OP_REQUEST, idx, amount);
    end
  endtask

  // One setting: program the count, fill every block in use, then random traffic
  task automatic run_phase(input logic [CFG_W-1:0] blocks, input int beats, input bit hold);
    int unsigned span;
    drain_and_settle();
    write_block_count(blocks);
    span = (blocks > BLOCK_COUNT) ? BLOCK_COUNT : blocks;
    for (int unsigned k = 0; k < span; k++)
      send_beat(OP_LOAD, INDEX_W'(k), SIZE_IN_W'($urandom_range(0, 65535)));
    for (int i = 0; i < beats; i++) begin
      if (hold && i == beats / 2) hold_req_cnt <= hold_req_cnt + 1;
      random_item();
    end
  endtask

  initial begin
    rst_ni        <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_wdata_i   <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= OP_LOAD;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty table at reset count: zero-size request takes block 0, anything else misses
    send_beat(OP_REQUEST, 5'd0, 16'd0);
    send_beat(OP_REQUEST, 5'd31, 16'd1);
    send_beat(OP_LOAD, 5'd31, 16'hFFFF);
    send_beat(OP_LOAD, 5'd0, 16'h8000);
    send_beat(OP_LOAD, 5'd5, 16'h8000);
    send_beat(OP_LOAD, 5'd3, 16'd100);
    send_beat(OP_LOAD, 5'd7, 16'd100);
    send_beat(OP_REQUEST, 5'd0, 16'hFFFF);  // exact fit drains the top block
    send_beat(OP_REQUEST, 5'd0, 16'h8000);  // tie, lowest index wins
    send_beat(OP_REQUEST, 5'd0, 16'd0);     // zero size leaves the block unchanged
    send_beat(OP_REQUEST, 5'd0, 16'd1);
    send_beat(OP_REQUEST, 5'd0, 16'h8000);  // nothing left that big

    // single block: loads past it are dropped
    drain_and_settle();
    write_block_count(6'd1);
    send_beat(OP_LOAD, 5'd3, 16'd500);
    send_beat(OP_LOAD, 5'd0, 16'd40);
    send_beat(OP_REQUEST, 5'd3, 16'd50);
    send_beat(OP_REQUEST, 5'd3, 16'd40);

    // no block in use: load dropped, request misses
    drain_and_settle();
    write_block_count(6'd0);
    send_beat(OP_LOAD, 5'd0, 16'd100);
    send_beat(OP_REQUEST, 5'd0, 16'd0);

    // random phases over several counts, including above the table
    run_phase(6'd1, 150, 1'b0);
    run_phase(6'd0, 60, 1'b0);
    run_phase(6'd63, 350, 1'b1);
    run_phase(6'd7, 250, 1'b0);
    run_phase(CFG_W'($urandom_range(2, 31)), 250, 1'b0);
    drain_and_settle();
    quiet = 1'b1;
    run_phase(6'd32, 300, 1'b0);
    drain_and_settle();

    $display("Covered %0d loads and %0d requests over %0d block-count settings.",
             loads_sent, requests_sent, settings_run);
    $display("Checked %0d grant beats, %0d of them allocated; %0d mismatches.",
             grants_checked, grants_made, mismatch_count);
    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Watchdog: well beyond the slowest legal run
  initial begin
    #10_000_000;
    $display("Timeout with %0d grants outstanding", grants_waiting);
    $display("TEST FAILED");
    $finish;
  end

endmodule
